/* src/dpcmue_pkg.sv */
// ----------------------------------------------------------------------------
// DPCM uniform encoder package
// Shared widths, quantizer limits and the helper that clamps the index width.
// ----------------------------------------------------------------------------
package dpcmue_pkg;

   // Field widths.
   localparam int unsigned SampleWidth = 9;
   localparam int unsigned CodeWidth   = 8;
   localparam int unsigned QbitsWidth  = 4;
   localparam int unsigned ReconWidth  = 8;

   // Quantizer index width limits and reset value.
   localparam logic [QbitsWidth-1:0] QbitsMin   = 4'd2;
   localparam logic [QbitsWidth-1:0] QbitsMax   = 4'd8;
   localparam logic [QbitsWidth-1:0] QbitsReset = 4'd4;

   // Offset of the difference range, in half units (twice 256).
   localparam logic [SampleWidth:0] DiffOffsetTwice = 10'd512;

   // Stage 1 status handed between the input and result sides.
   typedef struct packed {
      logic valid;
      logic first;
   } stage_ctrl_type;

   // Clamp a written index width into the supported range.
   function automatic logic [QbitsWidth-1:0] eff_bits(input logic [QbitsWidth-1:0] bits);
      logic [QbitsWidth-1:0] b;
      b = bits;
      if (b < QbitsMin) begin
         b = QbitsMin;
      end else if (b > QbitsMax) begin
         b = QbitsMax;
      end
      return b;
   endfunction

endpackage

/* src/dpcm_uniform_encoder_unit.sv */
// ----------------------------------------------------------------------------
// DPCM uniform encoder unit
// Codes a sample stream with a power-of-two uniform quantizer, absolutely for
// the first sample of a stream and differentially against a running 8-bit
// reconstruction afterward.
// ----------------------------------------------------------------------------
// Stage 1 holds the input transfer; the result register takes its code as it
// advances. Throughput: one sample per cycle unless the result side stalls;
// the reconstruction loop (shift, add, register) closes in one compute stage.
// Reset: synchronous, active high; clears the pipeline valid bits, sets the
// reconstruction to zero and the index width register to four.
module dpcm_uniform_encoder_unit
   import dpcmue_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] sample_twice, [15:9] zero fill
   input  logic        req_tuser,   // [0] first_sample
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] code
   // Index width register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   logic [QbitsWidth-1:0]  qbits_ff;
   stage_ctrl_type         s1_ctrl_ff, s1_ctrl_in;
   logic [SampleWidth-1:0] s1_sample_ff;
   logic [ReconWidth-1:0]  recon_ff, recon_in;
   logic                   rsp_valid_ff;
   logic [CodeWidth-1:0]   rsp_code_ff, code_in;

   logic                   s1_adv;
   logic [QbitsWidth-1:0]  bits;
   logic [QbitsWidth-1:0]  sh_step;
   logic [QbitsWidth-1:0]  sh_diff;
   logic [QbitsWidth-1:0]  sh_half;
   logic [CodeWidth-1:0]   top;
   logic [CodeWidth-1:0]   idx_first;
   logic [CodeWidth-1:0]   idx_diff;
   logic [SampleWidth:0]   diff_twice;
   logic [ReconWidth-1:0]  level_mod;
   logic [ReconWidth-1:0]  half_step;

   // Handshake control: stage 1 moves on when the result register is free.
   assign s1_adv     = s1_ctrl_ff.valid && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_ctrl_ff.valid || s1_adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;

   // Next stage 1 status.
   always_comb begin
      s1_ctrl_in = s1_ctrl_ff;
      if (req_tvalid && req_tready) begin
         s1_ctrl_in.valid = 1'b1;
         s1_ctrl_in.first = req_tuser;
      end else if (s1_adv) begin
         s1_ctrl_in.valid = 1'b0;
      end
   end

   // Quantizer shift amounts follow from the clamped index width.
   assign bits    = eff_bits(qbits_ff);
   assign sh_step = 4'd9 - bits;
   assign sh_diff = 4'd10 - bits;
   assign sh_half = 4'd8 - bits;
   assign top     = CodeWidth'((9'd1 << bits) - 9'd1);

   // Absolute index for the first sample, and the difference index otherwise.
   assign idx_first  = CodeWidth'(s1_sample_ff >> sh_step);
   assign diff_twice = {1'b0, s1_sample_ff} + DiffOffsetTwice - {1'b0, recon_ff, 1'b0};
   assign idx_diff   = CodeWidth'(diff_twice >> sh_diff);

   // Index and reconstruction update.
   always_comb begin
      code_in = s1_ctrl_ff.first ? idx_first : idx_diff;
      if (code_in > top) begin
         code_in = top;
      end
      level_mod = ReconWidth'({2'b00, code_in} << sh_step);
      half_step = ReconWidth'(9'd1 << sh_half);
      if (s1_ctrl_ff.first) begin
         recon_in = s1_sample_ff[SampleWidth-1:1];
      end else begin
         recon_in = recon_ff + level_mod + half_step;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         qbits_ff     <= QbitsReset;
         s1_ctrl_ff   <= '0;
         recon_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            qbits_ff <= csr_data;
         end
         s1_ctrl_ff <= s1_ctrl_in;
         if (s1_adv) begin
            recon_ff     <= recon_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_sample_ff <= req_tdata[SampleWidth-1:0];
      end
      if (s1_adv) begin
         rsp_code_ff <= code_in;
      end
   end

`ifndef SYNTHESIS
   // A stalled input side always means stage 1 holds an item.
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_ctrl_ff.valid)
      else $error("input stalled with stage 1 empty");

   // An offered code never exceeds the top level of the quantizer.
   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_code_ff <= top))
      else $error("code above the top quantizer level");

   // A first sample loads the reconstruction with the floor of the sample.
   a_first_loads_recon: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_ctrl_ff.first) |=> (recon_ff == $past(s1_sample_ff[SampleWidth-1:1])))
      else $error("reconstruction not loaded from a first sample");

   // The reconstruction only changes when an item leaves stage 1.
   a_recon_stable: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(recon_ff))
      else $error("reconstruction changed without a transfer");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// DPCM uniform encoder testbench
// Sends sample streams into the encoder and writes the index width register
// between phases. A scoreboard predicts each quantizer index, and every
// returned code is compared with the oldest prediction. Both stream sides
// stall at random, in three rounds with different stall rates.
// ----------------------------------------------------------------------------

// Predicts quantizer codes and holds the codes still owed by the encoder.
class dpcm_code_scoreboard;
   logic [dpcmue_pkg::ReconWidth-1:0] recon;
   logic [dpcmue_pkg::QbitsWidth-1:0] index_bits;
   logic [dpcmue_pkg::CodeWidth-1:0]  owed_codes[$];
   int unsigned                       failures;

   function new();
      recon      = '0;
      index_bits = dpcmue_pkg::QbitsReset;
      failures   = 0;
   endfunction

   function void set_index_bits(input logic [dpcmue_pkg::QbitsWidth-1:0] bits);
      index_bits = bits;
   endfunction

   // Work out the code of one accepted sample and advance the reconstruction.
   function void note_sample(input logic [dpcmue_pkg::SampleWidth-1:0] twice,
                             input logic start);
      int unsigned width;
      int unsigned top_code;
      int unsigned step;
      int unsigned offset_twice;
      int unsigned code;
      width = index_bits;
      if (width < dpcmue_pkg::QbitsMin) begin
         width = dpcmue_pkg::QbitsMin;
      end else if (width > dpcmue_pkg::QbitsMax) begin
         width = dpcmue_pkg::QbitsMax;
      end
      top_code = (1 << width) - 1;
      if (start) begin
         // Absolute coding over 0..256; the reconstruction takes the floor.
         code = twice >> (9 - width);
         if (code > top_code) begin
            code = top_code;
         end
         recon = twice[8:1];
      end else begin
         // Difference against the reconstruction, shifted up to stay positive.
         step         = 1 << (9 - width);
         offset_twice = twice + 512 - 2 * recon;
         code         = offset_twice >> (10 - width);
         if (code > top_code) begin
            code = top_code;
         end
         recon = 8'(recon + code * step + step / 2);
      end
      owed_codes.push_back(8'(code));
   endfunction

   // Compare one returned code with the oldest prediction.
   function void check_code(input logic [dpcmue_pkg::CodeWidth-1:0] code);
      logic [dpcmue_pkg::CodeWidth-1:0] wanted;
      if (owed_codes.size() == 0) begin
         $error("code: unexpected result %0d with nothing outstanding", code);
         failures++;
      end else begin
         wanted = owed_codes.pop_front();
         if (code !== wanted) begin
            $error("code mismatch: expected %0d, actual %0d", wanted, code);
            failures++;
         end
      end
   endfunction

   function int unsigned owed_count();
      return owed_codes.size();
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpcmue_pkg::*;

   localparam int unsigned QuietLimit    = 4000;
   localparam int unsigned PhaseSamples  = 128;
   localparam int unsigned SettleCycles  = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // [8:0] sample_twice, [15:9] zero fill
   logic                  req_tuser;   // [0] first_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] code
   logic                  csr_valid;
   logic                  csr_ready;
   logic [QbitsWidth-1:0] csr_data;

   dpcm_code_scoreboard board;
   int unsigned         req_idle_pct;
   int unsigned         rsp_idle_pct;
   int unsigned         quiet_cycles;

   // Index widths for the random phases, four per stall round.
   logic [QbitsWidth-1:0] width_plan[12] = '{4'd2, 4'd8, 4'd0, 4'd15,
                                             4'd3, 4'd5, 4'd6, 4'd7,
                                             4'd1, 4'd9, 4'd4, 4'd11};

   dpcm_uniform_encoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever begin
         #4 clock = ~clock;
      end
   end

   // Result side: stall at random and check every transfer.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_code(rsp_tdata);
      end
   end

   // Watchdog: end the run when no channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Offer one sample after a random gap and wait for its transfer.
   task automatic send_sample(input logic [SampleWidth-1:0] twice, input logic start);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {7'd0, twice};
      req_tuser  = start;
      do begin
         @(posedge clock);
      end while (!req_tready);
      board.note_sample(twice, start);
   endtask

   // Stop sending and hold off until every owed code has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.owed_count() > 0) begin
         @(posedge clock);
      end
   endtask

   // Write the index width register; only called while the encoder is idle.
   task automatic write_index_bits(input logic [QbitsWidth-1:0] bits);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = bits;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      board.set_index_bits(bits);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Streams of random length: mostly a start mark followed by a slow walk,
   // with jumps, extremes, unmarked streams and stray start marks mixed in.
   task automatic send_streams(input int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      int unsigned k;
      int          level;
      int          span;
      logic        marked;
      logic        start;
      logic [SampleWidth-1:0] twice;
      sent  = 0;
      level = $urandom_range(511);
      while (sent < count) begin
         run_len = $urandom_range(40, 1);
         span    = $urandom_range(64, 1);
         marked  = ($urandom_range(99) >= 10);
         for (k = 0; k < run_len && sent < count; k++) begin
            case ($urandom_range(9))
               0, 1: begin
                  twice = 9'($urandom_range(511));
               end
               2: begin
                  case ($urandom_range(3))
                     0: twice = 9'd0;
                     1: twice = 9'd1;
                     2: twice = 9'd510;
                     default: twice = 9'd511;
                  endcase
               end
               default: begin
                  level = level + int'($urandom_range(2 * span)) - span;
                  if (level < 0) begin
                     level = 0;
                  end else if (level > 511) begin
                     level = 511;
                  end
                  twice = level[8:0];
               end
            endcase
            start = (k == 0) ? marked : ($urandom_range(99) < 2);
            send_sample(twice, start);
            sent++;
         end
      end
   endtask

   // Reset, directed cases, then random phases over three stall rounds.
   initial begin
      int unsigned r;
      int unsigned s;
      board        = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      rsp_tready   = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      quiet_cycles = 0;
      req_idle_pct = 10;
      rsp_idle_pct = 56;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Width four from reset; the first stream starts without its mark.
      send_sample(9'd510, 1'b0);
      send_sample(9'd0, 1'b0);
      send_sample(9'd511, 1'b1);
      send_sample(9'd511, 1'b0);
      send_sample(9'd0, 1'b1);
      send_sample(9'd0, 1'b0);
      send_sample(9'd256, 1'b1);
      send_sample(9'd257, 1'b0);

      // A width below the range acts as two.
      drain();
      write_index_bits(4'd0);
      send_sample(9'd0, 1'b1);
      send_sample(9'd511, 1'b0);
      send_sample(9'd511, 1'b0);
      send_sample(9'd0, 1'b0);
      send_sample(9'd511, 1'b1);

      // A width above the range acts as eight.
      drain();
      write_index_bits(4'd15);
      send_sample(9'd0, 1'b1);
      send_sample(9'd511, 1'b0);
      send_sample(9'd0, 1'b0);
      send_sample(9'd511, 1'b1);
      send_sample(9'd510, 1'b0);
      send_sample(9'd1, 1'b0);

      drain();
      write_index_bits(4'd2);
      send_sample(9'd511, 1'b1);
      send_sample(9'd0, 1'b0);
      send_sample(9'd255, 1'b0);

      for (r = 0; r < 3; r++) begin
         case (r)
            0: begin
               req_idle_pct = 10;
               rsp_idle_pct = 56;
            end
            1: begin
               req_idle_pct = 56;
               rsp_idle_pct = 10;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (s = 0; s < 4; s++) begin
            drain();
            write_index_bits(width_plan[4 * r + s]);
            send_streams(PhaseSamples);
         end
      end

      drain();
      repeat (SettleCycles) @(posedge clock);
      if (board.owed_count() != 0) begin
         $error("code: %0d results never arrived", board.owed_count());
         board.failures++;
      end
      if (board.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
